// File: rtl/rrq_pkg.sv
// Shared types and constants for the round-robin queue with lazy removal.
// Used by the controller, the datapath and the top level; no dependencies.
package rrq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int ID_BITS     = 8;
  localparam int ID_SPACE    = 2 ** ID_BITS;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W     = 3;
  localparam int UID_W    = 8;
  localparam int OUT_ID_W = 8;
  localparam int QCNT_W   = 6;

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK = 3'd1;
  localparam logic [OP_W-1:0] OP_ADV  = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [UID_W-1:0] unit_id;
  } in_item_t;

  typedef struct packed {
    logic [OUT_ID_W-1:0] out_id;
    logic                id_valid;
    logic                last;
    logic [QCNT_W-1:0]   queue_count;
    logic                accepted;
  } out_item_t;

  typedef struct packed {
    logic clear_mark;
    logic load_in;
    logic push;
    logic mark;
    logic pop;
    logic latch_front;
    logic rotate;
    logic set_first;
    logic list_wr;
    logic emit_item;
    logic emit_list;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            clear_done;
    logic            count_zero;
    logic            front_dead;
    logic            front_first;
    logic            list_full;
    logic            list_empty;
    logic            emit_last;
    logic            out_free;
  } dp_status_t;

endpackage

// File: rtl/rrq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/rrq_ctrl.sv
// Sequencer for the round-robin queue: dispatch, front draining, listing, result delivery.
// Depends on rrq_pkg for the command and status structs and op codes.
module rrq_ctrl
  import rrq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_DRN_RD,
    ST_DRN_MK,
    ST_DRN_CHK,
    ST_AFTER,
    ST_EMIT,
    ST_LIST_RD,
    ST_LIST_EM
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        // zero one dead mark per cycle
        cmd.clear_mark = 1'b1;
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (status.op)
          OP_PUSH: begin
            cmd.push  = 1'b1;
            state_nxt = ST_EMIT;
          end
          OP_MARK: begin
            cmd.mark  = 1'b1;
            state_nxt = ST_EMIT;
          end
          OP_ADV, OP_PEEK, OP_LIST: state_nxt = ST_DRN_RD;
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_DRN_RD: state_nxt = ST_DRN_MK;
      ST_DRN_MK: state_nxt = ST_DRN_CHK;
      ST_DRN_CHK: begin
        if (status.count_zero) begin
          state_nxt = ST_AFTER;
        end else if (status.front_dead) begin
          cmd.pop   = 1'b1;
          state_nxt = ST_DRN_RD;
        end else begin
          cmd.latch_front = 1'b1;
          state_nxt       = ST_AFTER;
        end
      end
      ST_AFTER: begin
        case (status.op)
          OP_ADV: begin
            cmd.rotate = !status.count_zero;
            state_nxt  = ST_EMIT;
          end
          OP_LIST: begin
            if (status.count_zero) begin
              state_nxt = status.list_empty ? ST_EMIT : ST_LIST_RD;
            end else if (!status.list_empty &&
                         (status.front_first || status.list_full)) begin
              state_nxt = ST_LIST_RD;
            end else begin
              // record the front, move it to the back, then drain again
              cmd.set_first = status.list_empty;
              cmd.list_wr   = 1'b1;
              cmd.rotate    = 1'b1;
              state_nxt     = ST_DRN_RD;
            end
          end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_item = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_LIST_RD: state_nxt = ST_LIST_EM;
      ST_LIST_EM: begin
        if (status.out_free) begin
          cmd.emit_list = 1'b1;
          state_nxt     = status.emit_last ? ST_IDLE : ST_LIST_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/rrq_datapath.sv
// Datapath: ring storage, pointers, dead-mark bits, listing buffer and output register.
// Depends on rrq_pkg and rrq_ram.
module rrq_datapath
  import rrq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  logic [OP_W-1:0]     op_r;
  logic [ID_BITS-1:0]  uid_r;
  logic                acc_r;
  logic [PTR_W-1:0]    head_r;
  logic [CNT_W-1:0]    count_r;
  logic [ID_BITS-1:0]  front_r;
  logic [ID_BITS-1:0]  first_r;
  logic [CNT_W-1:0]    n_r;
  logic [PTR_W-1:0]    k_r;
  logic                clear_en_r;
  logic [ID_BITS-1:0]  clr_addr_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [ID_BITS-1:0] ring_rdata;
  logic [ID_BITS-1:0] buf_rdata;
  logic [CNT_W:0]     tail_sum;
  logic [PTR_W-1:0]   tail_addr;
  logic [PTR_W-1:0]   head_inc;
  logic               full;
  logic               push_ok;
  logic               ring_we;
  logic [ID_BITS-1:0] ring_wdata;
  logic               dead_we;
  logic [ID_BITS-1:0] dead_waddr;
  logic               dead_wdata;
  logic               dead_rdata;
  logic               out_free;
  logic               peek_valid;

  assign tail_sum  = (CNT_W + 1)'(head_r) + (CNT_W + 1)'(count_r);
  assign tail_addr = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH)) ?
                     PTR_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
  assign head_inc  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign push_ok   = cmd.push && !full;
  assign ring_we   = push_ok || cmd.rotate;
  assign ring_wdata = cmd.push ? uid_r : front_r;
  assign out_free  = !out_valid_r || out_ready;

  // set on mark, clear when the id leaves the front, zero during the clearing pass
  assign dead_we    = cmd.clear_mark || cmd.mark || cmd.pop;
  assign dead_waddr = cmd.clear_mark ? clr_addr_r : (cmd.mark ? uid_r : ring_rdata);
  assign dead_wdata = cmd.mark;

  rrq_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (tail_addr),
    .wr_data (ring_wdata),
    .rd_addr (head_r),
    .rd_data (ring_rdata)
  );

  rrq_ram #(.WIDTH(1), .DEPTH(ID_SPACE)) u_dead_marks (
    .clk     (clk),
    .wr_en   (dead_we),
    .wr_addr (dead_waddr),
    .wr_data (dead_wdata),
    .rd_addr (ring_rdata),
    .rd_data (dead_rdata)
  );

  rrq_ram #(.WIDTH(ID_BITS), .DEPTH(QUEUE_DEPTH)) u_list_buf (
    .clk     (clk),
    .wr_en   (cmd.list_wr),
    .wr_addr (n_r[PTR_W-1:0]),
    .wr_data (front_r),
    .rd_addr (k_r),
    .rd_data (buf_rdata)
  );

  always_comb begin
    status.op          = op_r;
    status.clear_done  = (clr_addr_r == ID_BITS'(ID_SPACE - 1));
    status.count_zero  = (count_r == '0);
    status.front_dead  = clear_en_r && dead_rdata;
    status.front_first = (front_r == first_r);
    status.list_full   = (n_r == CNT_W'(QUEUE_DEPTH));
    status.list_empty  = (n_r == '0);
    status.emit_last   = (CNT_W'(k_r) + CNT_W'(1) == n_r);
    status.out_free    = out_free;
  end

  assign peek_valid = (op_r == OP_PEEK) && (count_r != '0);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      clr_addr_r  <= '0;
      clear_en_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clear_en_r <= cfg_wr_data;
      end
      if (cmd.clear_mark) begin
        clr_addr_r <= clr_addr_r + ID_BITS'(1);
      end
      if (push_ok) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.pop) begin
        head_r  <= head_inc;
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.rotate) begin
        head_r <= head_inc;
      end
      if (cmd.emit_item || cmd.emit_list) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_data.op;
      uid_r <= in_data.unit_id[ID_BITS-1:0];
      acc_r <= 1'b1;
      n_r   <= '0;
      k_r   <= '0;
    end
    if (cmd.push && full) begin
      acc_r <= 1'b0;
    end
    if (cmd.latch_front) begin
      front_r <= ring_rdata;
    end
    if (cmd.set_first) begin
      first_r <= front_r;
    end
    if (cmd.list_wr) begin
      n_r <= n_r + CNT_W'(1);
    end
    if (cmd.emit_item) begin
      out_data_r.out_id      <= peek_valid ? OUT_ID_W'(front_r) : '0;
      out_data_r.id_valid    <= peek_valid;
      out_data_r.last        <= 1'b1;
      out_data_r.queue_count <= QCNT_W'(count_r);
      out_data_r.accepted    <= acc_r;
    end
    if (cmd.emit_list) begin
      out_data_r.out_id      <= OUT_ID_W'(buf_rdata);
      out_data_r.id_valid    <= 1'b1;
      out_data_r.last        <= status.emit_last;
      out_data_r.queue_count <= QCNT_W'(count_r);
      out_data_r.accepted    <= 1'b1;
      k_r                    <= k_r + PTR_W'(1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/round_robin_queue_lazy_removal_unit.sv
// Round-robin turn queue of unit ids with lazy removal of dead ids at the front.
// After reset a clearing pass zeroes the 256 dead marks, one per cycle, so in_ready stays
// low until the pass is done. Items are then taken one at a time. Push, mark_dead and
// unused codes pass a dispatch state and then an emit state that loads the result once
// the result register is free. Advance and peek first drain the front through ring read,
// dead-mark read and check states, repeated per dead id drained, since every look at the
// front is a registered ring read followed by a registered dead-mark read. A listing
// collects ids through the same drain, recording and rotating each front, then delivers
// them from a result buffer, because every result carries the final queue count. A result
// register decouples the output side. Depends on rrq_pkg, rrq_ctrl and rrq_datapath.
module round_robin_queue_lazy_removal_unit
  import rrq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rrq_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// File: sim/round_robin_queue_lazy_removal_unit_tb.sv
// Testbench for round_robin_queue_lazy_removal_unit: directed and random turn-queue traffic
// checked field by field against an in-bench model of the ring, dead marks and listings.
// Depends on rrq_pkg and the RTL of the unit.
module round_robin_queue_lazy_removal_unit_tb;
  import rrq_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
  localparam int SETTLE_CYCLES      = 12;
  localparam int QUIET_LIMIT        = 4000;
  localparam int RANDOM_PHASE_ITEMS = 16;

  logic      clk         = 1'b0;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;

  // model of the turn queue
  logic [ID_BITS-1:0] ring_ids [QUEUE_DEPTH];
  logic [PTR_W-1:0]   front_ptr;
  logic [CNT_W-1:0]   queued;
  bit                 dead_mark [ID_SPACE];
  bit                 lazy_clear;
  out_item_t          results_due [$];

  int        fail_count   = 0;
  int        quiet_cycles = 0;
  int        ready_hold   = 0;
  bit        calm_phase   = 1'b0;
  out_item_t due;

  round_robin_queue_lazy_removal_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #2 clk = ~clk;

  function automatic void reset_turn_model();
    front_ptr  = '0;
    queued     = '0;
    lazy_clear = 1'b1;
    foreach (ring_ids[i]) ring_ids[i] = '0;
    foreach (dead_mark[i]) dead_mark[i] = 1'b0;
  endfunction

  function automatic void drop_dead_front();
    while (lazy_clear && queued != 0 && dead_mark[ring_ids[front_ptr]]) begin
      dead_mark[ring_ids[front_ptr]] = 1'b0;
      front_ptr++;
      queued--;
    end
  endfunction

  function automatic void rotate_turn();
    drop_dead_front();
    if (queued != 0) begin
      ring_ids[PTR_W'(front_ptr + queued)] = ring_ids[front_ptr];
      front_ptr++;
    end
  endfunction

  function automatic out_item_t turn_result(logic [ID_BITS-1:0] id, logic id_ok,
                                            logic fin, logic acc);
    out_item_t r;
    r.out_id      = id;
    r.id_valid    = id_ok;
    r.last        = fin;
    r.queue_count = '0;
    r.accepted    = acc;
    return r;
  endfunction

  // Apply one transfer to the model and queue the results it causes.
  function automatic void predict_queue_op(in_item_t op_in);
    out_item_t          batch [QUEUE_DEPTH];
    int                 n;
    bit                 stop;
    logic [ID_BITS-1:0] first_id;
    n = 0;
    case (op_in.op)
      OP_PUSH: begin
        if (queued == QUEUE_DEPTH) begin
          batch[n++] = turn_result('0, 1'b0, 1'b1, 1'b0);
        end else begin
          ring_ids[PTR_W'(front_ptr + queued)] = op_in.unit_id;
          queued++;
          batch[n++] = turn_result('0, 1'b0, 1'b1, 1'b1);
        end
      end
      OP_MARK: begin
        dead_mark[op_in.unit_id] = 1'b1;
        batch[n++] = turn_result('0, 1'b0, 1'b1, 1'b1);
      end
      OP_ADV: begin
        rotate_turn();
        batch[n++] = turn_result('0, 1'b0, 1'b1, 1'b1);
      end
      OP_PEEK: begin
        drop_dead_front();
        if (queued == 0) batch[n++] = turn_result('0, 1'b0, 1'b1, 1'b1);
        else batch[n++] = turn_result(ring_ids[front_ptr], 1'b1, 1'b1, 1'b1);
      end
      OP_LIST: begin
        drop_dead_front();
        if (queued != 0) begin
          first_id = ring_ids[front_ptr];
          stop = 1'b0;
          while (!stop && n < QUEUE_DEPTH) begin
            drop_dead_front();
            if (queued == 0) begin
              stop = 1'b1;
            end else begin
              batch[n++] = turn_result(ring_ids[front_ptr], 1'b1, 1'b0, 1'b1);
              rotate_turn();
              drop_dead_front();
              stop = (queued == 0) || (ring_ids[front_ptr] == first_id);
            end
          end
        end
        if (n == 0) batch[n++] = turn_result('0, 1'b0, 1'b1, 1'b1);
        else batch[n-1].last = 1'b1;
      end
      default: begin
        batch[n++] = turn_result('0, 1'b0, 1'b1, 1'b1);
      end
    endcase
    for (int i = 0; i < n; i++) begin
      batch[i].queue_count = queued;
      results_due = {results_due, batch[i]};
    end
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result: expected none, actual %p", $time, out_data);
      end else begin
        due = results_due.pop_front();
        compare_field("out_id", due.out_id, out_data.out_id);
        compare_field("id_valid", 8'(due.id_valid), 8'(out_data.id_valid));
        compare_field("last", 8'(due.last), 8'(out_data.last));
        compare_field("queue_count", 8'(due.queue_count), 8'(out_data.queue_count));
        compare_field("accepted", 8'(due.accepted), 8'(out_data.accepted));
      end
    end
  end

  // Result side back-pressure in random bursts, none in the calm phase
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_ready <= 1'b0;
    end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
      ready_hold = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("** round_robin_queue_lazy_removal_unit: FAILED **");
    $finish;
  end

  // Call at a falling edge; returns at the falling edge after the transfer, valid held.
  task automatic send_op(logic [OP_W-1:0] op, logic [UID_W-1:0] uid);
    in_item_t op_in;
    op_in.op      = op;
    op_in.unit_id = uid;
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data  <= op_in;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_queue_op(in_data);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_lazy_clear(bit enable);
    wait_idle();
    cfg_wr_data <= enable;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en  <= 1'b0;
    lazy_clear = enable;
  endtask

  task automatic test_empty_queue();
    send_op(OP_PEEK, 8'h00);
    send_op(OP_ADV, 8'hFF);
    send_op(OP_LIST, 8'h00);
    send_op(OP_SPARE_FIRST, 8'hFF);
    send_op(OP_W'(OP_SPARE_FIRST + 1), 8'h3C);
    send_op(OP_SPARE_LAST, 8'h00);
    // mark an id before it is queued; it must drop once it reaches the front
    send_op(OP_MARK, 8'h81);
  endtask

  task automatic test_basic_turns();
    send_op(OP_PUSH, 8'h00);
    send_op(OP_PUSH, 8'hFF);
    send_op(OP_PUSH, 8'h81);
    send_op(OP_PUSH, 8'h7E);
    send_op(OP_PEEK, 8'h00);
    send_op(OP_ADV, 8'h00);
    send_op(OP_PEEK, 8'h00);
    send_op(OP_LIST, 8'h00);
    send_op(OP_MARK, 8'hFF);
    send_op(OP_ADV, 8'h00);
    send_op(OP_LIST, 8'h00);
    // duplicate id: the listing stops when the copy comes around
    send_op(OP_PUSH, 8'h7E);
    send_op(OP_ADV, 8'h00);
    send_op(OP_LIST, 8'h00);
    // only the first marked copy leaves
    send_op(OP_MARK, 8'h7E);
    send_op(OP_LIST, 8'h00);
  endtask

  task automatic test_full_queue();
    logic [UID_W-1:0] base_id;
    logic [UID_W-1:0] snap [$];
    base_id = UID_W'($urandom_range(0, 255));
    set_lazy_clear(1'b1);
    while (queued < QUEUE_DEPTH) send_op(OP_PUSH, base_id + UID_W'(queued));
    send_op(OP_PUSH, UID_W'($urandom_range(0, 255)));
    send_op(OP_PUSH, UID_W'($urandom_range(0, 255)));
    send_op(OP_LIST, 8'h00);
    send_op(OP_PEEK, 8'h00);
    for (int i = 0; i < queued; i++) snap = {snap, ring_ids[PTR_W'(front_ptr + i)]};
    foreach (snap[i]) send_op(OP_MARK, snap[i]);
    // every entry dead: the listing drains them all
    send_op(OP_LIST, 8'h00);
    send_op(OP_PEEK, 8'h00);
  endtask

  task automatic test_lazy_removal_off();
    set_lazy_clear(1'b0);
    send_op(OP_PUSH, 8'h3C);
    send_op(OP_PUSH, 8'hC3);
    send_op(OP_PUSH, 8'h3C);
    send_op(OP_MARK, 8'h3C);
    send_op(OP_PEEK, 8'h00);
    send_op(OP_ADV, 8'h00);
    send_op(OP_LIST, 8'h00);
    set_lazy_clear(1'b1);
    send_op(OP_PEEK, 8'h00);
    send_op(OP_ADV, 8'h00);
    send_op(OP_PEEK, 8'h00);
    send_op(OP_LIST, 8'h00);
  endtask

  task automatic send_random_op();
    int               pick;
    logic [UID_W-1:0] uid;
    pick = $urandom_range(0, 99);
    uid  = UID_W'($urandom_range(0, 255));
    if (pick < 5) begin
      send_op(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), uid);
    end else if (pick < 35) begin
      // few values so duplicates show up
      if ($urandom_range(0, 2) == 0) uid = UID_W'($urandom_range(0, 7));
      send_op(OP_PUSH, uid);
    end else if (pick < 52) begin
      if (queued != 0 && $urandom_range(0, 3) != 0)
        uid = ring_ids[PTR_W'(front_ptr + $urandom_range(0, queued - 1))];
      send_op(OP_MARK, uid);
    end else if (pick < 67) begin
      send_op(OP_ADV, uid);
    end else if (pick < 84) begin
      send_op(OP_PEEK, uid);
    end else begin
      send_op(OP_LIST, uid);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 3; phase++) begin
      set_lazy_clear(1'($urandom_range(0, 1)));
      calm_phase = (phase == 2);
      repeat (RANDOM_PHASE_ITEMS) send_random_op();
    end
  endtask

  initial begin
    reset_turn_model();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_queue();
    test_basic_turns();
    test_full_queue();
    test_lazy_removal_off();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0) $display("** round_robin_queue_lazy_removal_unit: PASSED **");
    else $display("** round_robin_queue_lazy_removal_unit: FAILED **");
    $finish;
  end

endmodule
